[rtl/bphs_pkg.sv]
// bphs_pkg: shared types, function codes and constants for the beta-profile halo splatter
// holds the beat structs, the stored pixel word and the 2^(2^-(k+1)) root table
// no dependencies
package bphs_pkg;

  // function codes of an input beat
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [47:0] SUM_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] HALO_MAX = 16'hFFFF;

  // log2 result: 6 integer bits, 16 fraction bits
  localparam int LG_W  = 22;
  // exponent 0.5 - 3*beta in Q7.12, signed (two's complement, 12 fraction bits)
  localparam int EXP_W = 19;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [11:0] center_x;
    logic signed [11:0] center_y;
    logic [31:0]        peak_brightness;
    logic [15:0]        core_radius;
    logic [15:0]        cut_radius;
    logic [15:0]        slope;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [47:0] intensity;
    logic [15:0] halo_tag;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic [47:0] sum;
    logic [15:0] tag;
  } pixel_t;

  // roots 2^(2^-(k+1)) in Q1.30, by repeated integer square roots from 2.0
  function automatic logic [15:0][30:0] root_table();
    logic [63:0]        c;
    logic [63:0]        v;
    logic [63:0]        res;
    logic [63:0]        bt;
    logic [15:0][30:0]  tab;
    c = 64'd2 << 30;
    for (int k = 0; k < 16; k++) begin
      v   = c << 30;
      res = '0;
      bt  = 64'd1 << 62;
      for (int q = 0; q < 32; q++) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      c      = res;
      tab[k] = c[30:0];
    end
    return tab;
  endfunction

endpackage

[rtl/bphs_mem.sv]
// bphs_mem: pixel store holding the brightness sum and halo tag of every pixel
// one write port, one read port, registered read data; uses bphs_pkg
module bphs_mem #(
  parameter int DEPTH = 1048576,
  parameter int ADW   = 20
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [ADW-1:0]   wr_addr_i,
  input  bphs_pkg::pixel_t wr_data_i,
  input  logic             rd_en_i,
  input  logic [ADW-1:0]   rd_addr_i,
  output bphs_pkg::pixel_t rd_data_o
);

  bphs_pkg::pixel_t mem_q [DEPTH];
  bphs_pkg::pixel_t rd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[rtl/bphs_term.sv]
// bphs_term: iterative unit for one halo term s0 * (A / w)^e
// normalise, log2 by squaring, scale by exponent, exp2 by root products; uses bphs_pkg
module bphs_term #(
  parameter int AW = 35
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [AW-1:0]                     a_i,
  input  logic [bphs_pkg::LG_W-1:0]         lw_i,
  input  logic signed [bphs_pkg::EXP_W-1:0] e_i,
  input  logic [31:0]                       s0_i,
  output logic                              done_o,
  output logic [bphs_pkg::LG_W-1:0]         lg_o,
  output logic [47:0]                       term_o
);

  localparam logic [15:0][30:0] ROOTS = bphs_pkg::root_table();

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_NORM  = 3'd1;
  localparam logic [2:0] T_SQR   = 3'd2;
  localparam logic [2:0] T_PROD  = 3'd3;
  localparam logic [2:0] T_ROUND = 3'd4;
  localparam logic [2:0] T_EXP   = 3'd5;
  localparam logic [2:0] T_SCALE = 3'd6;
  localparam logic [2:0] T_SHIFT = 3'd7;

  logic [2:0]         state_q;
  logic [3:0]         step_q;
  logic [AW-1:0]      norm_q;
  logic [5:0]         sh_q;
  logic [30:0]        m_q;
  logic [5:0]         intp_q;
  logic [15:0]        frac_q;
  logic signed [40:0] p_q;
  logic [15:0]        f_q;
  logic signed [13:0] n_q;
  logic [62:0]        prod_q;
  logic [47:0]        term_q;
  logic               done_q;

  logic [5:0]         amt;
  logic               top_zero;
  logic [AW-1:0]      norm_d;
  logic [5:0]         sh_d;
  logic [61:0]        sq;
  logic [31:0]        sq_s;
  logic [bphs_pkg::LG_W-1:0] l_val;
  logic signed [41:0] p_full;
  logic               neg;
  logic [40:0]        mag;
  logic [28:0]        magr;
  logic signed [29:0] t_v;
  logic [61:0]        ep;
  logic signed [14:0] sh_v;
  logic [62:0]        shifted;
  logic [47:0]        term_d;

  // datapath for each step
  always_comb begin
    amt      = 6'd32 >> step_q[2:0];
    top_zero = ((norm_q >> (AW - int'(amt))) == '0);
    norm_d   = top_zero ? (norm_q << amt) : norm_q;
    sh_d     = top_zero ? (sh_q + amt) : sh_q;

    sq   = m_q * m_q;
    sq_s = sq[61:30];

    l_val  = {intp_q, frac_q} - lw_i;
    p_full = $signed({1'b0, l_val}) * e_i;

    neg  = p_q[40];
    mag  = neg ? 41'(-p_q) : 41'(p_q);
    magr = 29'((mag + 41'd2048) >> 12);
    t_v  = neg ? -$signed({1'b0, magr}) : $signed({1'b0, magr});

    ep = m_q * ROOTS[step_q];

    sh_v    = 15'sd30 - 15'(n_q);
    shifted = prod_q >> sh_v[5:0];
    if (sh_v >= 15'sd64) begin
      term_d = '0;
    end else if (sh_v > 15'sd0) begin
      term_d = (|shifted[62:48]) ? bphs_pkg::SUM_MAX : shifted[47:0];
    end else begin
      term_d = (prod_q != '0) ? bphs_pkg::SUM_MAX : '0;
    end
  end

  // control sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == T_SHIFT);
      case (state_q)
        T_IDLE: begin
          if (start_i) begin
            state_q <= T_NORM;
            step_q  <= '0;
          end
        end
        T_NORM: begin
          if (step_q == 4'd5) begin
            state_q <= T_SQR;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        T_SQR: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            state_q <= T_PROD;
          end
        end
        T_PROD:  state_q <= T_ROUND;
        T_ROUND: begin
          state_q <= T_EXP;
          step_q  <= '0;
        end
        T_EXP: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            state_q <= T_SCALE;
          end
        end
        T_SCALE: state_q <= T_SHIFT;
        T_SHIFT: state_q <= T_IDLE;
        default: state_q <= T_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      T_IDLE: begin
        norm_q <= a_i;
        sh_q   <= '0;
      end
      T_NORM: begin
        norm_q <= norm_d;
        sh_q   <= sh_d;
        if (step_q == 4'd5) begin
          m_q    <= norm_d[AW-1 -: 31];
          intp_q <= 6'(AW - 1) - sh_d;
          frac_q <= '0;
        end
      end
      T_SQR: begin
        frac_q <= {frac_q[14:0], sq_s[31]};
        m_q    <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
      end
      T_PROD: p_q <= p_full[40:0];
      T_ROUND: begin
        f_q <= t_v[15:0];
        n_q <= t_v[29:16];
        m_q <= 31'd1 << 30;
      end
      T_EXP: begin
        if (f_q[4'd15 - step_q]) begin
          m_q <= ep[60:30];
        end
      end
      T_SCALE: prod_q <= s0_i * m_q;
      T_SHIFT: term_q <= term_d;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign lg_o   = {intp_q, frac_q};
  assign term_o = term_q;

endmodule

[rtl/beta_profile_halo_splat.sv]
// beta_profile_halo_splat: top level, draws beta-model halos into a pixel store
// uses bphs_pkg, bphs_mem (pixel store) and bphs_term (term unit)
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o | bphs_pkg::in_item_t
//  out     | output    | out_valid_o / out_stall_i | bphs_pkg::out_item_t
//
// one item at a time. an add walks (2*rmax+1)^2 offsets: an offset that is skipped is
//   stepped over in S_SCAN, each pixel drawn waits in S_TERM for the iterative term unit,
//   after set-up states that take log2 of the squared core radius.
// a read in range goes via S_RDWAIT to S_RESP; a clear writes one store entry a cycle.
// after reset a clearing pass over all IMG_SIDE*IMG_SIDE entries runs with in_stall_o high.
// the result sits in an output register; the next item is taken while it is stalled.
module beta_profile_halo_splat #(
  parameter int IMG_SIDE = 1024,
  parameter int RCUT_MAX = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bphs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bphs_pkg::out_item_t out_data_o
);

  localparam int RW    = $clog2(RCUT_MAX + 1);
  localparam int R2W   = 2 * RW + 1;
  localparam int SW    = R2W + 16;
  localparam int CMPW  = (SW > 32) ? SW : 32;
  localparam int AW    = CMPW + 1;
  localparam int AXW   = $clog2(IMG_SIDE);
  localparam int DEPTH = IMG_SIDE * IMG_SIDE;
  localparam int ADW   = $clog2(DEPTH);
  localparam int XW0   = (RW + 2 > 13) ? RW + 2 : 13;
  localparam int XW    = (AXW + 2 > XW0) ? AXW + 2 : XW0;
  localparam int CUT_LIM = RCUT_MAX * 256;

  localparam logic signed [XW-1:0] SIDE_S = XW'(IMG_SIDE);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_LWGO   = 4'd3;
  localparam logic [3:0] S_LW     = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_TERM   = 4'd6;
  localparam logic [3:0] S_RDWAIT = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0]                       state_q;
  bphs_pkg::in_item_t               item_q;
  logic [ADW-1:0]                   clr_cnt_q;
  logic                             clr_resp_q;
  logic [15:0]                      halo_cnt_q;
  logic [15:0]                      tag_q;
  logic [31:0]                      w_q;
  logic [31:0]                      cut2_q;
  logic signed [bphs_pkg::EXP_W-1:0] e_q;
  logic [RW-1:0]                    rmax_q;
  logic signed [RW:0]               oi_q;
  logic signed [RW:0]               oj_q;
  logic [ADW-1:0]                   addr_q;
  logic [bphs_pkg::LG_W-1:0]        lw_q;
  bphs_pkg::out_item_t              res_q;
  bphs_pkg::out_item_t              out_q;
  logic                             out_valid_q;

  logic               accept;
  logic               rd_inside;
  logic [ADW-1:0]     rd_addr_c;
  logic [15:0]        cut_c;
  logic [17:0]        slope3;
  logic [15:0]        cnt_next;
  logic signed [RW:0] rmax_s;
  logic signed [2*RW+1:0] sq_i;
  logic signed [2*RW+1:0] sq_j;
  logic [R2W-1:0]     r2;
  logic signed [XW-1:0] x_s;
  logic signed [XW-1:0] y_s;
  logic               hit;
  logic [ADW-1:0]     addr_c;
  logic               last_off;
  logic [48:0]        sum_w;
  logic [47:0]        sum_sat;

  logic               term_start;
  logic [AW-1:0]      term_a;
  logic               term_done;
  logic [bphs_pkg::LG_W-1:0] term_lg;
  logic [47:0]        term_val;

  logic               mem_wr_en;
  logic [ADW-1:0]     mem_wr_addr;
  bphs_pkg::pixel_t   mem_wr_data;
  logic               mem_rd_en;
  logic [ADW-1:0]     mem_rd_addr;
  bphs_pkg::pixel_t   mem_rd_data;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // read address for a read beat
  always_comb begin
    rd_inside = (32'(in_data_i.pixel_x) < 32'(IMG_SIDE)) &&
                (32'(in_data_i.pixel_y) < 32'(IMG_SIDE));
    rd_addr_c = ADW'(AXW'(in_data_i.pixel_y)) * ADW'(IMG_SIDE) +
                ADW'(AXW'(in_data_i.pixel_x));
  end

  // halo set-up values
  always_comb begin
    cut_c    = (32'(item_q.cut_radius) > 32'(CUT_LIM)) ? 16'(CUT_LIM) : item_q.cut_radius;
    slope3   = 18'(item_q.slope) * 18'd3;
    cnt_next = (halo_cnt_q == bphs_pkg::HALO_MAX) ? halo_cnt_q : halo_cnt_q + 16'd1;
  end

  // current offset: squared radius, pixel position and address
  always_comb begin
    rmax_s   = $signed({1'b0, rmax_q});
    sq_i     = oi_q * oi_q;
    sq_j     = oj_q * oj_q;
    r2       = R2W'(sq_i) + R2W'(sq_j);
    x_s      = XW'($signed(item_q.center_x)) + XW'(oi_q);
    y_s      = XW'($signed(item_q.center_y)) + XW'(oj_q);
    hit      = (x_s >= 0) && (x_s < SIDE_S) && (y_s >= 0) && (y_s < SIDE_S) &&
               (CMPW'({r2, 16'h0}) < CMPW'(cut2_q));
    addr_c   = ADW'(AXW'($unsigned(y_s))) * ADW'(IMG_SIDE) +
               ADW'(AXW'($unsigned(x_s)));
    last_off = (oi_q == rmax_s) && (oj_q == rmax_s);
  end

  // saturating accumulate of the term into the stored sum
  always_comb begin
    sum_w   = {1'b0, mem_rd_data.sum} + {1'b0, term_val};
    sum_sat = sum_w[48] ? bphs_pkg::SUM_MAX : sum_w[47:0];
  end

  // term unit request
  always_comb begin
    term_start = (state_q == S_LWGO) || ((state_q == S_SCAN) && hit);
    term_a     = (state_q == S_LWGO) ? AW'(w_q) : AW'(w_q) + AW'({r2, 16'h0});
  end

  // store ports; pixels of one halo are distinct and each write lands before the next read
  always_comb begin
    mem_wr_en   = (state_q == S_CLEAR) || ((state_q == S_TERM) && term_done);
    mem_wr_addr = (state_q == S_CLEAR) ? clr_cnt_q : addr_q;
    mem_wr_data = (state_q == S_CLEAR) ? '0 : {sum_sat, tag_q};
    mem_rd_en   = (accept && (in_data_i.func == bphs_pkg::FUNC_READ) && rd_inside) ||
                  ((state_q == S_SCAN) && hit);
    mem_rd_addr = accept ? rd_addr_c : addr_c;
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      clr_resp_q <= 1'b0;
      halo_cnt_q <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (clr_cnt_q == ADW'(DEPTH - 1)) begin
            clr_cnt_q  <= '0;
            clr_resp_q <= 1'b0;
            state_q    <= clr_resp_q ? S_RESP : S_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + ADW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data_i.func)
              bphs_pkg::FUNC_ADD: begin
                state_q <= (in_data_i.core_radius == '0) ? S_RESP : S_SETUP;
              end
              bphs_pkg::FUNC_READ: state_q <= rd_inside ? S_RDWAIT : S_RESP;
              bphs_pkg::FUNC_CLEAR: begin
                clr_resp_q <= 1'b1;
                state_q    <= S_CLEAR;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_SETUP: begin
          halo_cnt_q <= cnt_next;
          state_q    <= S_LWGO;
        end
        S_LWGO: state_q <= S_LW;
        S_LW: begin
          if (term_done) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            state_q <= S_TERM;
          end else if (last_off) begin
            state_q <= S_RESP;
          end
        end
        S_TERM: begin
          if (term_done) begin
            state_q <= last_off ? S_RESP : S_SCAN;
          end
        end
        S_RDWAIT: state_q <= S_RESP;
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // item, halo and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_CLEAR: res_q <= '0;
      S_IDLE: begin
        if (accept) begin
          item_q <= in_data_i;
          res_q  <= '{intensity: '0, halo_tag: '0,
                      status: (in_data_i.func == bphs_pkg::FUNC_ADD) &&
                              (in_data_i.core_radius == '0)};
        end
      end
      S_SETUP: begin
        w_q    <= 32'(item_q.core_radius) * 32'(item_q.core_radius);
        cut2_q <= 32'(cut_c) * 32'(cut_c);
        e_q    <= 19'sd2048 - $signed({1'b0, slope3});
        rmax_q <= RW'(cut_c[15:8]);
        oi_q   <= -$signed({1'b0, RW'(cut_c[15:8])});
        oj_q   <= -$signed({1'b0, RW'(cut_c[15:8])});
        tag_q  <= cnt_next;
        res_q  <= '{intensity: '0, halo_tag: cnt_next, status: 1'b0};
      end
      S_LW: begin
        if (term_done) begin
          lw_q <= term_lg;
        end
      end
      S_SCAN, S_TERM: begin
        if ((state_q == S_SCAN) && hit) begin
          addr_q <= addr_c;
        end
        // step to the next offset, rows inside columns
        if (((state_q == S_SCAN) && !hit) || ((state_q == S_TERM) && term_done)) begin
          if (oj_q == rmax_s) begin
            oj_q <= -rmax_s;
            oi_q <= oi_q + (RW+1)'(1);
          end else begin
            oj_q <= oj_q + (RW+1)'(1);
          end
        end
      end
      S_RDWAIT: begin
        res_q <= '{intensity: mem_rd_data.sum, halo_tag: mem_rd_data.tag, status: 1'b0};
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_RESP) && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_RESP) && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bphs_term #(
    .AW (AW)
  ) u_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (term_start),
    .a_i     (term_a),
    .lw_i    (lw_q),
    .e_i     (e_q),
    .s0_i    (item_q.peak_brightness),
    .done_o  (term_done),
    .lg_o    (term_lg),
    .term_o  (term_val)
  );

  bphs_mem #(
    .DEPTH (DEPTH),
    .ADW   (ADW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

endmodule

[rtl/bphs_checker.sv]
// bphs_checker: port-level checks for beta_profile_halo_splat, bound to the top level
// uses bphs_pkg
module bphs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bphs_pkg::out_item_t out_data_o
);

  // a stalled result beat stays and holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // one item at a time: an accepted beat closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // a rejected add carries no sum and no tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> (out_data_o.intensity == '0) &&
                                         (out_data_o.halo_tag == '0))
    else $error("rejected add with non-zero payload");

endmodule

bind beta_profile_halo_splat bphs_checker u_bphs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
